### hdl/mrwbc_pkg.sv
// Shared types and constants for the multi-round weighted byte checksum.
// Holds the controller-to-datapath command struct and the mixing constants.
// No dependencies.
`default_nettype none

package mrwbc_pkg;

    // Golden-ratio constant added in every fold.
    localparam logic [63:0] GOLDEN_MIX   = 64'h9e37_79b9_7f4a_7c15;
    // Per-round multiple of the plain sum.
    localparam logic [63:0] ROUND_STRIDE = 64'd131;
    localparam int unsigned ROUND_W      = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_byte;    // add the accepted byte to both sums
        logic prep;        // load the round operands from the sums
        logic round_step;  // fold one round that is not the last
        logic finish;      // fold the last round, load the result, clear the sums
    } cmd_t;

endpackage

`default_nettype wire

### hdl/mrwbc_ctrl.sv
// Controller for the multi-round weighted byte checksum.
// Sequences byte accumulation, round preparation and the mixing rounds.
// Depends on mrwbc_pkg.
`default_nettype none

module mrwbc_ctrl
    import mrwbc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                last_byte,
    input  wire logic                message_empty,
    output logic                     in_ready,
    input  wire logic                cfg_valid,
    input  wire logic [ROUND_W-1:0]  cfg_data,
    output logic                     cfg_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cmd_t                     cmd
);

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_PREP,
        ST_ROUND
    } state_t;

    state_t               state_reg, state_next;
    logic [ROUND_W-1:0]   round_idx_reg, round_idx_next;
    logic [ROUND_W-1:0]   round_count_reg, round_count_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 in_fire;
    logic [ROUND_W-1:0]   last_round_idx;
    logic                 last_round;
    logic                 out_free;

    // Handshake terms
    assign in_ready  = (state_reg == ST_ACCEPT);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Treat a round count of zero as a single round
    assign last_round_idx = (round_count_reg == '0) ? '0 : round_count_reg - ROUND_W'(1);
    assign last_round     = (round_idx_reg == last_round_idx);

    // Decode commands for the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.acc_byte   = in_fire && !message_empty;
        cmd.prep       = (state_reg == ST_PREP);
        cmd.round_step = (state_reg == ST_ROUND) && !last_round;
        cmd.finish     = (state_reg == ST_ROUND) && last_round && out_free;
    end

    // Next state, round counter, output flag and configuration
    always_comb
    begin
        state_next       = state_reg;
        round_idx_next   = round_idx_reg;
        round_count_next = round_count_reg;
        out_valid_next   = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            round_count_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_ACCEPT:
            begin
                if (in_fire && (message_empty || last_byte))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                round_idx_next = '0;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (cmd.round_step)
                begin
                    round_idx_next = round_idx_reg + ROUND_W'(1);
                end
                else if (cmd.finish)
                begin
                    out_valid_next = 1'b1;
                    round_idx_next = '0;
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_ACCEPT;
            round_idx_reg   <= '0;
            round_count_reg <= ROUND_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            round_idx_reg   <= round_idx_next;
            round_count_reg <= round_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/mrwbc_datapath.sv
// Datapath for the multi-round weighted byte checksum.
// Holds the running sums, the round operands and the result register.
// Depends on mrwbc_pkg.
`default_nettype none

module mrwbc_datapath
    import mrwbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [7:0]  data_byte,
    output logic      [63:0] checksum_value
);

    logic [63:0] pos_reg, pos_next;
    logic [63:0] plain_reg, plain_next;
    logic [63:0] weighted_reg, weighted_next;
    logic [63:0] step_reg, step_next;
    logic [63:0] value_reg, value_next;
    logic [63:0] mix_reg, mix_next;
    logic [63:0] out_reg, out_next;

    logic [8:0]  term;
    logic [63:0] pos_inc;
    logic [72:0] weight_prod;
    logic [63:0] folded;

    // Byte term and its weight at the new position
    assign term        = {1'b0, data_byte} + 9'd1;
    assign pos_inc     = pos_reg + 64'd1;
    assign weight_prod = pos_inc * term;

    // One golden-ratio fold of the current round value
    assign folded = mix_reg ^ (value_reg + GOLDEN_MIX + (mix_reg << 6) + (mix_reg >> 2));

    assign checksum_value = out_reg;

    // Next values of the sums and round operands
    always_comb
    begin
        pos_next      = pos_reg;
        plain_next    = plain_reg;
        weighted_next = weighted_reg;
        step_next     = step_reg;
        value_next    = value_reg;
        mix_next      = mix_reg;
        out_next      = out_reg;

        if (cmd.acc_byte)
        begin
            pos_next      = pos_inc;
            plain_next    = plain_reg + {55'd0, term};
            weighted_next = weighted_reg + weight_prod[63:0];
        end

        if (cmd.prep)
        begin
            step_next  = plain_reg * ROUND_STRIDE;
            value_next = weighted_reg;
            mix_next   = '0;
        end

        if (cmd.round_step)
        begin
            mix_next   = folded;
            value_next = value_reg + step_reg;
        end

        // Deliver the result and drop the message state
        if (cmd.finish)
        begin
            out_next      = folded;
            pos_next      = '0;
            plain_next    = '0;
            weighted_next = '0;
        end
    end

    // Message sums: cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            plain_reg    <= '0;
            weighted_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            plain_reg    <= plain_next;
            weighted_reg <= weighted_next;
        end
    end

    // Round operands and result: payload only
    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        value_reg <= value_next;
        mix_reg   <= mix_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

### hdl/multi_round_weighted_byte_checksum_top.sv
// Top level of the multi-round weighted byte checksum.
// Joins mrwbc_ctrl and mrwbc_datapath; depends on mrwbc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per
//   transaction with last_byte and message_empty flags. A byte that does not
//   end the message keeps the block accepting, so bytes stream at one per cycle.
//   A transaction with last_byte or message_empty set starts the finish: a
//   preparation step, then round_count mixing rounds through the single fold
//   unit (a round count of zero runs one round). in_ready is low until the
//   last round has run. The checksum appears on the output channel
//   (out_valid/out_ready) the cycle after the last round. The result waits
//   in an output register, so the next message streams in while it is held;
//   if it is still not taken when the next message reaches its last round,
//   the block holds there until it is.
//   Configuration channel (cfg_valid/cfg_ready) writes round_count; it is
//   always ready and should be used only while the block is idle.
//   Reset clears the sums, returns to accepting bytes, drops out_valid and
//   sets round_count to one.
`default_nettype none

module multi_round_weighted_byte_checksum_top
    import mrwbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic        message_empty,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [63:0] checksum_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    cmd_t cmd;

    mrwbc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .last_byte     (last_byte),
        .message_empty (message_empty),
        .in_ready      (in_ready),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .cfg_ready     (cfg_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cmd           (cmd)
    );

    mrwbc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .data_byte      (data_byte),
        .checksum_value (checksum_value)
    );

    // At most one datapath operation per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.acc_byte, cmd.prep, cmd.round_step, cmd.finish}))
        else $error("overlapping datapath commands");

    // A finished message always presents its result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result not presented after finish");

    // No byte is taken while rounds are being prepared or run
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.prep || cmd.round_step || cmd.finish) |-> !in_ready)
        else $error("input accepted during rounds");

    // The result register is loaded only when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || out_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
